// ----- design/epu_pkg.sv -----
// epu_pkg: shared types, codes and constants of the ember spark engine.
// No dependencies; every other design file imports it.
`default_nettype none

package epu_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_EMIT_LEFT  = 3'd0;
  localparam logic [2:0] REG_EMIT_RIGHT = 3'd1;
  localparam logic [2:0] REG_EMIT_EDGE  = 3'd2;
  localparam logic [2:0] REG_EMIT_RATE  = 3'd3;
  localparam logic [2:0] REG_INIT_SPEED = 3'd4;
  localparam logic [2:0] REG_LIFETIME   = 3'd5;
  localparam logic [2:0] REG_BASE_SIZE  = 3'd6;
  localparam logic [2:0] REG_SPREAD     = 3'd7;

  localparam logic [23:0] RST_EMIT_RATE  = 24'd38400;
  localparam logic [23:0] RST_INIT_SPEED = 24'd35840;
  localparam logic [23:0] RST_LIFETIME   = 24'd147456;
  localparam logic [15:0] RST_BASE_SIZE  = 16'd512;
  localparam logic [8:0]  RST_SPREAD     = 9'd256;

  localparam logic [31:0] PRNG_SEED   = 32'h1234abcd;
  localparam logic [31:0] PRNG_REFILL = 32'h9e3779b9;
  localparam logic [12:0] DT_MAX      = 13'd6554;
  localparam logic [15:0] SWAY_RATE   = 16'd62582;
  localparam logic [13:0] K_015       = 14'd9830;
  localparam logic [15:0] K_060       = 16'd39322;
  localparam logic [15:0] K_080       = 16'd52429;
  localparam logic [15:0] K_090       = 16'd58982;
  localparam logic [14:0] POLY_A      = 15'd25736;
  localparam logic [13:0] POLY_B      = 14'd10512;
  localparam logic [10:0] POLY_C      = 11'd1160;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [23:0]        life_left;
    logic [23:0]        life_total;
    logic [15:0]        spark_size;
    logic [15:0]        sway_seed;
  } spark_t;

  typedef enum logic [4:0] {
    S_IDLE, S_T_SWAY, S_T_ACCUM, S_T_GMUL, S_T_GDT, S_T_SMUL, S_T_SDT,
    S_SP_CHECK, S_SP_X, S_SP_Y, S_SP_F, S_SP_VY, S_SP_VMUL, S_SP_VSCALE,
    S_SP_VX, S_SP_LF, S_SP_LIFE, S_SP_SF, S_SP_SIZE, S_SP_SEED,
    S_U_CHECK, S_U_WAIT, S_U_MOVE, S_U_SINE, S_U_VEL, S_U_PX, S_U_PY,
    S_U_WB, S_RD_WAIT, S_RESULT
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/epu_spark_mem.sv -----
// epu_spark_mem: spark pool storage, one write port, one registered read port.
// Depends on epu_pkg for the spark record.
`default_nettype none

module epu_spark_mem #(
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output epu_pkg::spark_t                 rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  epu_pkg::spark_t                 wr_data
);
  import epu_pkg::*;

  spark_t mem [DEPTH];
  spark_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/epu_prng.sv -----
// epu_prng: 32-bit xorshift generator with zero-state refill.
// Depends on epu_pkg for the seed and refill constants.
`default_nettype none

module epu_prng (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        draw,
  output logic [23:0]      rnd
);
  import epu_pkg::*;

  logic [31:0] state_r;
  logic [31:0] x1, x2, x3;

  always_comb begin
    x1 = state_r ^ (state_r << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
  end

  assign rnd = x3[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PRNG_SEED;
    end else if (draw) begin
      state_r <= (x3 == 32'd0) ? PRNG_REFILL : x3;
    end
  end

endmodule

`default_nettype wire

// ----- design/epu_sine.sv -----
// epu_sine: five-stage sine unit, quarter-wave polynomial on a quantized angle.
// Depends on epu_pkg for the polynomial constants.
`default_nettype none

module epu_sine #(
  parameter int SINE_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [15:0]        angle,
  output logic                    done,
  output logic signed [16:0]      value
);
  import epu_pkg::*;

  localparam int SHIFT = 16 - $clog2(SINE_ENTRIES);

  logic [15:0] t;
  logic [14:0] x_in;
  logic [14:0] x_r;
  logic [1:0]  q_r;
  logic [14:0] x2_r;
  logic [13:0] y1_r;
  logic [14:0] y2_r;
  logic signed [16:0] value_r;
  logic [4:0]  vld_r;
  logic [29:0] sq;
  logic [25:0] cx;
  logic [28:0] yx;
  logic [29:0] fin;
  logic [15:0] mag;

  always_comb begin
    t = (angle >> SHIFT) << SHIFT;
    x_in = {1'b0, t[13:0]};
    if (t[14]) begin
      x_in = 15'd16384 - {1'b0, t[13:0]};
    end
    sq  = 30'(x_r) * 30'(x_r);
    cx  = 26'(POLY_C) * 26'(x2_r);
    yx  = 29'(y1_r) * 29'(x2_r);
    fin = 30'(x_r) * 30'(y2_r);
    mag = 16'(fin >> 13);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      q_r <= t[15:14];
    end
    x2_r <= 15'(sq >> 14);
    y1_r <= POLY_B - 14'(cx >> 14);
    y2_r <= POLY_A - 15'(yx >> 14);
    value_r <= q_r[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end

  assign done  = vld_r[4];
  assign value = value_r;

  a_sine_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##5 done)
    else $error("sine result did not appear five cycles after start");

endmodule

`default_nettype wire

// ----- design/ember_particle_update.sv -----
// ember_particle_update: top level of the ember spark engine, sequencer and datapath.
// Depends on epu_pkg, epu_spark_mem, epu_prng and epu_sine.
//
//  channel  direction  handshake             payload
//  in_      into block in_valid / in_stall   in_command, in_dt, in_index
//  out_     from block out_valid / out_stall out_valid_res, out_live_count, spark fields
//  cfg_     into block cfg_wr_en             cfg_index, cfg_wdata
//
// Items are taken one at a time. A tick runs its setup states, then the spawn
// states once per spawned spark, then the update states once per surviving
// spark and a move once per removed spark; the spark memory with one read and
// one write port and the five-stage sine unit lie on the per-spark path.
// Reset: rst_n low for one edge empties the pool and reloads registers.
// Stalls: a finished result waits in the output register; the next item is
// taken once the result has been loaded there.
`default_nettype none

module ember_particle_update #(
  parameter int CAPACITY     = 1024,
  parameter int SINE_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [24:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [15:0]        in_dt,
  input  wire logic [9:0]         in_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_valid_res,
  output logic [10:0]             out_live_count,
  output logic signed [23:0]      out_pos_x,
  output logic signed [23:0]      out_pos_y,
  output logic signed [23:0]      out_vel_x,
  output logic signed [23:0]      out_vel_y,
  output logic [23:0]             out_life_left,
  output logic [23:0]             out_life_total,
  output logic [15:0]             out_spark_size,
  output logic [15:0]             out_sway_seed
);
  import epu_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // configuration registers
  logic signed [23:0] emit_left_r, emit_right_r;
  logic [24:0] emit_edge_r;
  logic [23:0] emit_rate_r, init_speed_r, lifetime_r;
  logic [15:0] base_size_r;
  logic [8:0]  spread_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_left_r  <= '0;
      emit_right_r <= '0;
      emit_edge_r  <= '0;
      emit_rate_r  <= RST_EMIT_RATE;
      init_speed_r <= RST_INIT_SPEED;
      lifetime_r   <= RST_LIFETIME;
      base_size_r  <= RST_BASE_SIZE;
      spread_r     <= RST_SPREAD;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EMIT_LEFT:  emit_left_r  <= cfg_wdata[23:0];
        REG_EMIT_RIGHT: emit_right_r <= cfg_wdata[23:0];
        REG_EMIT_EDGE:  emit_edge_r  <= cfg_wdata;
        REG_EMIT_RATE:  emit_rate_r  <= cfg_wdata[23:0];
        REG_INIT_SPEED: init_speed_r <= cfg_wdata[23:0];
        REG_LIFETIME:   lifetime_r   <= cfg_wdata[23:0];
        REG_BASE_SIZE:  base_size_r  <= cfg_wdata[15:0];
        REG_SPREAD:     spread_r     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t state_r, state_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [15:0] sway_r, sway_nxt;
  logic [13:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;

  // payload registers
  cmd_t cmd_r, cmd_nxt;
  logic [12:0] dt_r, dt_nxt;
  logic ok_r, ok_nxt;
  logic [39:0] prod_r, prod_nxt;
  logic [18:0] gdt_r, gdt_nxt;
  logic [20:0] sdt_r, sdt_nxt;
  logic [32:0] f_r, f_nxt;
  logic signed [24:0] d_r, d_nxt;
  logic signed [38:0] sprod_r, sprod_nxt;
  spark_t w_r, w_nxt;
  spark_t res_r, res_nxt;
  logic res_ok_r, res_ok_nxt;
  logic [10:0] res_live_r, res_live_nxt;

  // memory, generator and sine unit
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  spark_t rd_data, wr_data;
  logic draw;
  logic [23:0] rnd;
  logic sine_start, sine_done;
  logic [15:0] sine_angle;
  logic signed [16:0] sine_val;

  epu_spark_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  epu_prng u_prng (.clk(clk), .rst_n(rst_n), .draw(draw), .rnd(rnd));

  epu_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine (
    .clk(clk), .rst_n(rst_n), .start(sine_start), .angle(sine_angle),
    .done(sine_done), .value(sine_val)
  );

  // shared decisions
  logic accept, edge_ok, room, more, dead, out_free;
  logic [AW+9:0] idx_ext;
  logic [CW+10:0] live_ext;
  logic [CW-1:0] last;

  always_comb begin
    accept   = in_valid && (state_r == S_IDLE);
    edge_ok  = emit_right_r > emit_left_r;
    room     = live_r < CW'(CAPACITY);
    more     = i_r < live_r;
    dead     = rd_data.life_left <= 24'(dt_r);
    out_free = !out_valid_r || !out_stall;
    idx_ext  = (AW + 10)'(in_index);
    live_ext = (CW + 11)'(live_r);
    last     = live_r - 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_TICK:  state_nxt = (in_dt == 16'd0) ? S_RESULT : S_T_SWAY;
            CMD_READ:  state_nxt = S_RD_WAIT;
            default:   state_nxt = S_RESULT;
          endcase
        end
      end
      S_T_SWAY:    state_nxt = S_T_ACCUM;
      S_T_ACCUM:   state_nxt = S_T_GMUL;
      S_T_GMUL:    state_nxt = S_T_GDT;
      S_T_GDT:     state_nxt = S_T_SMUL;
      S_T_SMUL:    state_nxt = S_T_SDT;
      S_T_SDT:     state_nxt = S_SP_CHECK;
      S_SP_CHECK:  state_nxt = (count_r != '0 && edge_ok && room) ? S_SP_X : S_U_CHECK;
      S_SP_X:      state_nxt = S_SP_Y;
      S_SP_Y:      state_nxt = S_SP_F;
      S_SP_F:      state_nxt = S_SP_VY;
      S_SP_VY:     state_nxt = S_SP_VMUL;
      S_SP_VMUL:   state_nxt = S_SP_VSCALE;
      S_SP_VSCALE: state_nxt = S_SP_VX;
      S_SP_VX:     state_nxt = S_SP_LF;
      S_SP_LF:     state_nxt = S_SP_LIFE;
      S_SP_LIFE:   state_nxt = S_SP_SF;
      S_SP_SF:     state_nxt = S_SP_SIZE;
      S_SP_SIZE:   state_nxt = S_SP_SEED;
      S_SP_SEED:   state_nxt = S_SP_CHECK;
      S_U_CHECK:   state_nxt = more ? S_U_WAIT : S_RESULT;
      S_U_WAIT:    state_nxt = dead ? S_U_MOVE : S_U_SINE;
      S_U_MOVE:    state_nxt = S_U_CHECK;
      S_U_SINE:    state_nxt = sine_done ? S_U_VEL : S_U_SINE;
      S_U_VEL:     state_nxt = S_U_PX;
      S_U_PX:      state_nxt = S_U_PY;
      S_U_PY:      state_nxt = S_U_WB;
      S_U_WB:      state_nxt = S_U_CHECK;
      S_RD_WAIT:   state_nxt = S_RESULT;
      S_RESULT:    state_nxt = out_free ? S_IDLE : S_RESULT;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs of each state
  logic [28:0] m_sway;
  logic [36:0] m_rate;
  logic [37:0] m_g;
  logic [36:0] m_s;
  logic [48:0] m_x;
  logic [39:0] m_y;
  logic [32:0] m_spr;
  logic [56:0] m_vy;
  logic [48:0] m_v;
  logic signed [58:0] m_vx;
  logic [39:0] m_r;
  logic [40:0] m_life;
  logic [32:0] m_size;
  logic signed [37:0] m_p;
  logic [29:0] acc_sum;
  logic [24:0] diff;
  logic [14:0] off;
  logic [24:0] life_v;
  logic [16:0] size_v;

  always_comb begin
    m_sway = 29'(dt_r) * 29'(SWAY_RATE);
    m_rate = 37'(emit_rate_r) * 37'(dt_r);
    acc_sum = 30'(accum_r) + 30'(m_rate >> 8);
    m_g    = 38'(prod_r[39:16]) * 38'(dt_r);
    m_s    = 37'(prod_r[39:16]) * 37'(dt_r);
    diff   = 25'(emit_right_r) - 25'(emit_left_r);
    m_x    = 49'(diff) * 49'(rnd);
    m_y    = 40'(base_size_r) * 40'(rnd);
    off    = 15'(m_y >> 25);
    m_spr  = 33'(spread_r) * 33'(rnd);
    m_vy   = 57'(init_speed_r) * 57'(f_r);
    m_v    = 49'(f_r) * 49'(K_080);
    m_vx   = 59'(d_r) * $signed(59'(f_r));
    m_r    = 40'(rnd) * 40'((state_r == S_SP_SF) ? K_090 : K_080);
    m_life = 41'(lifetime_r) * 41'(f_r[16:0]);
    life_v = 25'(m_life >> 16);
    m_size = 33'(base_size_r) * 33'(f_r[16:0]);
    size_v = 17'(m_size >> 16);
    m_p    = 38'((state_r == S_U_PX) ? w_r.vel_x : w_r.vel_y) * $signed(38'(dt_r));

    live_nxt = live_r;
    i_nxt = i_r;
    accum_nxt = accum_r;
    sway_nxt = sway_r;
    count_nxt = count_r;
    cmd_nxt = cmd_r;
    dt_nxt = dt_r;
    ok_nxt = ok_r;
    prod_nxt = prod_r;
    gdt_nxt = gdt_r;
    sdt_nxt = sdt_r;
    f_nxt = f_r;
    d_nxt = d_r;
    sprod_nxt = sprod_r;
    w_nxt = w_r;
    res_nxt = res_r;
    res_ok_nxt = res_ok_r;
    res_live_nxt = res_live_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en = 1'b0;
    rd_addr = i_r[AW-1:0];
    wr_en = 1'b0;
    wr_addr = i_r[AW-1:0];
    wr_data = w_r;
    draw = 1'b0;
    sine_start = 1'b0;
    sine_angle = sway_r + rd_data.sway_seed;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_command);
          dt_nxt = (in_dt > 16'(DT_MAX)) ? DT_MAX : in_dt[12:0];
          ok_nxt = (CW + 10)'(in_index) < (CW + 10)'(live_r);
          rd_addr = idx_ext[AW-1:0];
          if (cmd_t'(in_command) == CMD_READ) begin
            rd_en = 1'b1;
          end
          if (cmd_t'(in_command) == CMD_RESET) begin
            live_nxt = '0;
            accum_nxt = '0;
            sway_nxt = '0;
          end
        end
      end
      S_T_SWAY:  sway_nxt = sway_r + 16'(m_sway >> 16);
      S_T_ACCUM: begin
        accum_nxt = acc_sum[15:0];
        count_nxt = acc_sum[29:16];
      end
      S_T_GMUL:  prod_nxt = 40'(init_speed_r) * 40'(K_015);
      S_T_GDT:   gdt_nxt = 19'(m_g >> 16);
      S_T_SMUL:  prod_nxt = 40'(init_speed_r) * 40'(K_060);
      S_T_SDT:   sdt_nxt = 21'(m_s >> 16);
      S_SP_CHECK: begin
        // drain whole units even when nothing can be spawned
        if (!(edge_ok && room)) begin
          count_nxt = '0;
        end
        if (count_r == '0 || !(edge_ok && room)) begin
          i_nxt = '0;
        end
      end
      S_SP_X: begin
        draw = 1'b1;
        w_nxt.pos_x = sat24(64'(emit_left_r) + 64'(m_x >> 24));
      end
      S_SP_Y: begin
        draw = 1'b1;
        w_nxt.pos_y = emit_edge_r[24] ?
          sat24(64'($signed(emit_edge_r[23:0])) + 64'(off)) :
          sat24(64'($signed(emit_edge_r[23:0])) - 64'(off));
      end
      S_SP_F: begin
        draw = 1'b1;
        f_nxt = 33'h1_0000_0000 - 33'(m_spr >> 1);
      end
      S_SP_VY: w_nxt.vel_y = sat24(-64'(m_vy >> 32));
      S_SP_VMUL: begin
        draw = 1'b1;
        d_nxt = $signed({1'b0, rnd}) - 25'sh0800000;
        f_nxt = 33'(init_speed_r) * 33'(spread_r);
      end
      S_SP_VSCALE: f_nxt = 33'(m_v >> 16);
      S_SP_VX: w_nxt.vel_x = sat24(64'(m_vx >>> 32));
      S_SP_LF: begin
        draw = 1'b1;
        f_nxt = 33'(K_060) + 33'(m_r >> 24);
      end
      S_SP_LIFE: begin
        w_nxt.life_left = (life_v > 25'hFFFFFF) ? 24'hFFFFFF : life_v[23:0];
        w_nxt.life_total = w_nxt.life_left;
      end
      S_SP_SF: begin
        draw = 1'b1;
        f_nxt = 33'(K_060) + 33'(m_r >> 24);
      end
      S_SP_SIZE: w_nxt.spark_size = (size_v > 17'hFFFF) ? 16'hFFFF : size_v[15:0];
      S_SP_SEED: begin
        draw = 1'b1;
        wr_en = 1'b1;
        wr_addr = live_r[AW-1:0];
        wr_data.sway_seed = rnd[23:8];
        live_nxt = live_r + 1'b1;
        count_nxt = count_r - 1'b1;
      end
      S_U_CHECK: begin
        rd_en = more;
      end
      S_U_WAIT: begin
        w_nxt = rd_data;
        if (dead) begin
          // fetch the last spark to fill this slot
          rd_en = 1'b1;
          rd_addr = last[AW-1:0];
        end else begin
          w_nxt.life_left = rd_data.life_left - 24'(dt_r);
          sine_start = 1'b1;
        end
      end
      S_U_MOVE: begin
        wr_en = 1'b1;
        wr_data = rd_data;
        live_nxt = last;
      end
      S_U_SINE: begin
        if (sine_done) begin
          sprod_nxt = 39'(sine_val) * $signed(39'(sdt_r));
        end
      end
      S_U_VEL: begin
        w_nxt.vel_x = sat24(64'(w_r.vel_x) + 64'(sprod_r >>> 15));
        w_nxt.vel_y = sat24(64'(w_r.vel_y) + 64'(gdt_r));
      end
      S_U_PX: w_nxt.pos_x = sat24(64'(w_r.pos_x) + 64'(m_p >>> 16));
      S_U_PY: w_nxt.pos_y = sat24(64'(w_r.pos_y) + 64'(m_p >>> 16));
      S_U_WB: begin
        wr_en = 1'b1;
        i_nxt = i_r + 1'b1;
      end
      S_RD_WAIT: w_nxt = rd_data;
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_ok_nxt = (cmd_r == CMD_READ) && ok_r;
          res_nxt = ((cmd_r == CMD_READ) && ok_r) ? w_r : '0;
          res_live_nxt = live_ext[10:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r <= '0;
      i_r <= '0;
      accum_r <= '0;
      sway_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r <= live_nxt;
      i_r <= i_nxt;
      accum_r <= accum_nxt;
      sway_r <= sway_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    dt_r <= dt_nxt;
    ok_r <= ok_nxt;
    prod_r <= prod_nxt;
    gdt_r <= gdt_nxt;
    sdt_r <= sdt_nxt;
    f_r <= f_nxt;
    d_r <= d_nxt;
    sprod_r <= sprod_nxt;
    w_r <= w_nxt;
    res_r <= res_nxt;
    res_ok_r <= res_ok_nxt;
    res_live_r <= res_live_nxt;
  end

  // hold the input while the sequencer is busy
  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_ok_r;
  assign out_live_count = res_live_r;
  assign out_pos_x      = res_r.pos_x;
  assign out_pos_y      = res_r.pos_y;
  assign out_vel_x      = res_r.vel_x;
  assign out_vel_y      = res_r.vel_y;
  assign out_life_left  = res_r.life_left;
  assign out_life_total = res_r.life_total;
  assign out_spark_size = res_r.spark_size;
  assign out_sway_seed  = res_r.sway_seed;

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(CAPACITY))
    else $error("live count above pool capacity");

  a_spawn_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SP_SEED) |=> (live_r == $past(live_r) + 1'b1))
    else $error("spawn did not add exactly one spark");

  a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == CMD_RESET) |=>
      (live_r == '0 && accum_r == '0 && sway_r == '0))
    else $error("pool reset left state behind");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SP_SEED || state_r == S_U_MOVE || state_r == S_U_WB))
    else $error("spark memory written outside a write state");

endmodule

`default_nettype wire
